/* src/pli_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

  localparam int DATA_W = 32;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  localparam logic [1:0] ST_INTERP   = 2'd0;
  localparam logic [1:0] ST_LOW      = 2'd1;
  localparam logic [1:0] ST_HIGH     = 2'd2;
  localparam logic [1:0] ST_FALLBACK = 2'd3;

  typedef struct packed {
    logic                     mode;
    logic [3:0]               point_index;
    logic signed [DATA_W-1:0] abscissa;
    logic signed [DATA_W-1:0] ordinate;
    logic signed [DATA_W-1:0] sample_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               status;
  } rsp_t;

  typedef struct packed {
    logic [4:0] point_count;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } entry_t;

endpackage

`default_nettype wire

/* src/pli_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface pli_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/pli_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module pli_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [2*pli_pkg::DATA_W-1:0] dividend,
  input  logic [pli_pkg::DATA_W-1:0]   divisor,
  output logic                     done,
  output logic [pli_pkg::DATA_W-1:0]   quotient
);
  import pli_pkg::*;

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] low;
  logic [DATA_W-1:0] dsr;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              take;

  assign trial    = {rem, low[DATA_W-1]};
  assign diff     = trial - {1'b0, dsr};
  assign take     = trial >= {1'b0, dsr};
  assign quotient = low;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(DATA_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[2*DATA_W-1:DATA_W];
      low <= dividend[DATA_W-1:0];
      dsr <= divisor;
    end else if (cnt != '0) begin
      rem <= take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      low <= {low[DATA_W-2:0], take};
    end
  end

endmodule

`default_nettype wire

/* src/piecewise_linear_interpolator.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Role    Payload
// cfg      sink    point_count, number of active breakpoints
// req      sink    mode, point_index, abscissa, ordinate, sample_value
// rsp      source  result_value, status (one per evaluate request)
//
// An evaluate request reads the breakpoint memory one entry per cycle and ends in a low
// clamp, a high clamp, a scan of the active intervals that ends in a fallback, or an
// interpolation through the multiply and the shift-subtract divider.
// Reset is synchronous and leaves the memory contents undefined. A finished result
// waits in the output register, and the next evaluate request stalls at its end.

module piecewise_linear_interpolator #(
  parameter int POINTS = 16
) (
  input logic        clk,
  input logic        rst,
  pli_stream_if.sink   cfg,
  pli_stream_if.sink   req,
  pli_stream_if.source rsp
);
  import pli_pkg::*;

  localparam int AW = $clog2(POINTS);
  localparam int CW = (AW + 1 > 5) ? AW + 1 : 5;

  typedef enum logic [2:0] {
    S_IDLE, S_LOW, S_HIGH, S_SCAN, S_MUL, S_DIVGO, S_DIV, S_DONE
  } state_t;

  state_t state;

  entry_t mem [POINTS];
  entry_t rd_data;
  logic [AW-1:0] rd_addr;

  logic [4:0]    point_count;
  logic [AW-1:0] last;
  logic [AW-1:0] last_next;
  logic [AW-1:0] k;

  logic signed [DATA_W-1:0] v;
  entry_t                   prev;
  logic signed [DATA_W-1:0] y_last;
  logic signed [DATA_W-1:0] y_base;
  logic signed [DATA_W:0]   dy;
  logic [DATA_W-1:0]        dv;
  logic [DATA_W-1:0]        dx;
  logic                     neg;
  logic [2*DATA_W-1:0]      prod;
  rsp_t                     pending;

  logic                     req_fire;
  logic                     load_ok;
  logic [CW-1:0]            pc_ext;
  logic signed [DATA_W:0]   dy_now;
  logic [DATA_W:0]          dy_mag;
  logic                     in_ivl;

  logic                     div_start;
  logic                     div_done;
  logic [DATA_W-1:0]        div_q;
  logic signed [DATA_W+1:0] sq;
  logic signed [DATA_W+1:0] sum;
  logic signed [DATA_W-1:0] sat_sum;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign load_ok   = CW'(req.data.point_index) < CW'(POINTS);
  assign pc_ext    = CW'(point_count);

  always_comb begin
    if (pc_ext == '0) begin
      last_next = '0;
    end else if (pc_ext > CW'(POINTS)) begin
      last_next = AW'(POINTS - 1);
    end else begin
      last_next = AW'(pc_ext - 1'b1);
    end
  end

  always_comb begin
    unique case (state)
      S_IDLE:  rd_addr = '0;
      S_LOW:   rd_addr = last;
      S_HIGH:  rd_addr = AW'(1);
      S_SCAN:  rd_addr = k + 1'b1;
      default: rd_addr = k;
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_fire && req.data.mode == MODE_LOAD && load_ok) begin
      mem[AW'(req.data.point_index)] <= '{x: req.data.abscissa, y: req.data.ordinate};
    end
    rd_data <= mem[rd_addr];
  end

  assign dy_now = {rd_data.y[DATA_W-1], rd_data.y} - {prev.y[DATA_W-1], prev.y};
  assign dy_mag = dy[DATA_W] ? -dy : dy;
  assign in_ivl = (v >= prev.x) && (v < rd_data.x);

  assign div_start = (state == S_DIVGO);

  pli_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (dx),
    .done     (div_done),
    .quotient (div_q)
  );

  assign sq  = neg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
  assign sum = $signed({{2{y_base[DATA_W-1]}}, y_base}) + sq;

  always_comb begin
    if (sum[DATA_W+1:DATA_W-1] == 3'b000 || sum[DATA_W+1:DATA_W-1] == 3'b111) begin
      sat_sum = sum[DATA_W-1:0];
    end else if (sum[DATA_W+1]) begin
      sat_sum = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_sum = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= 5'd1;
      rsp.valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        point_count <= cfg.data.point_count;
      end
      if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire && req.data.mode == MODE_EVAL) begin
            v     <= req.data.sample_value;
            last  <= last_next;
            state <= S_LOW;
          end
        end
        S_LOW: begin
          prev <= rd_data;
          if (v <= rd_data.x) begin
            pending <= '{result_value: rd_data.y, status: ST_LOW};
            state   <= S_DONE;
          end else begin
            state <= S_HIGH;
          end
        end
        S_HIGH: begin
          y_last <= rd_data.y;
          if (v >= rd_data.x) begin
            pending <= '{result_value: rd_data.y, status: ST_HIGH};
            state   <= S_DONE;
          end else begin
            k     <= AW'(1);
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (in_ivl) begin
            y_base <= prev.y;
            dy     <= dy_now;
            dv     <= DATA_W'(v - prev.x);
            dx     <= DATA_W'(rd_data.x - prev.x);
            state  <= S_MUL;
          end else if (k == last) begin
            pending <= '{result_value: y_last, status: ST_FALLBACK};
            state   <= S_DONE;
          end else begin
            prev <= rd_data;
            k    <= k + 1'b1;
          end
        end
        S_MUL: begin
          neg   <= dy[DATA_W];
          prod  <= dy_mag[DATA_W-1:0] * dv;
          state <= S_DIVGO;
        end
        S_DIVGO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            pending <= '{result_value: sat_sum, status: ST_INTERP};
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.data <= pending;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
